[rtl/png_unf_pkg.sv]
// Shared types, register codes and the Paeth predictor for the PNG scanline unfilter.
// No dependencies; every other file of the block except png_unf_ram imports this package.
package png_unf_pkg;

  localparam int unsigned ROW_BYTES_W  = 17;
  localparam int unsigned PIX_BYTES_W  = 3;
  localparam int unsigned IMAGE_ROWS_W = 15;
  localparam int unsigned ROW_IDX_W    = 14;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned Q_DEPTH      = 4;
  localparam int unsigned Q_PTR_W      = 2;
  localparam int unsigned Q_CNT_W      = 3;

  localparam logic [IMAGE_ROWS_W-1:0] ROWS_LIMIT = 15'd16384;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 2'd2;

  localparam logic [2:0] FLT_NONE  = 3'd0;
  localparam logic [2:0] FLT_SUB   = 3'd1;
  localparam logic [2:0] FLT_UP    = 3'd2;
  localparam logic [2:0] FLT_AVG   = 3'd3;
  localparam logic [2:0] FLT_PAETH = 3'd4;

  typedef enum logic [1:0] {
    OP_FILTER = 2'd0,
    OP_DATA   = 2'd1,
    OP_ERROR  = 2'd2
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] raw;
    logic       last_row;
    logic       last_img;
    logic       first_row;
  } item_t;

  typedef struct packed {
    logic accept;
    logic reads_above;
  } fstat_t;

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic [10:0]        pa;
    logic [10:0]        pb;
    logic [10:0]        pc;
    da = $signed({3'b000, b}) - $signed({3'b000, c});
    db = $signed({3'b000, a}) - $signed({3'b000, c});
    dc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
    pa = da[10] ? 11'(-da) : 11'(da);
    pb = db[10] ? 11'(-db) : 11'(db);
    pc = dc[10] ? 11'(-dc) : 11'(dc);
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end
    return c;
  endfunction

endpackage

[rtl/png_unf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module png_unf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/png_unf_front.sv]
// Front end: accepts raw bytes, tracks row and column, classifies each byte and
// issues the line store read. Depends on png_unf_pkg.
module png_unf_front
  import png_unf_pkg::*;
#(
  parameter int unsigned AW = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [ROW_BYTES_W-1:0]  rb_i,
  input  logic [IMAGE_ROWS_W-1:0] rows_i,
  input  logic                    in_valid_i,
  input  logic [7:0]              raw_byte_i,
  output logic                    in_stall_o,
  output logic [AW-1:0]           rd_addr_o,
  input  logic [Q_CNT_W-1:0]      q_count_i,
  input  logic                    q_hit_i,
  output logic                    push_valid_o,
  output item_t                   push_item_o,
  output logic [AW-1:0]           push_idx_o,
  output fstat_t                  stat_o
);

  logic [AW-1:0]        column_q, column_d;
  logic [ROW_IDX_W-1:0] row_q, row_d;
  logic                 expect_q, expect_d;
  logic                 discard_q, discard_d;
  logic                 s1_valid_q, s1_valid_d;
  item_t                s1_item_q, s1_item_d;
  logic [AW-1:0]        s1_idx_q;

  logic                 accept;
  logic                 room;
  logic                 reads_above;
  logic                 haz;
  logic                 last_row;
  logic                 last_img;
  logic [Q_CNT_W-1:0]   occ;

  assign occ         = q_count_i + Q_CNT_W'(s1_valid_q);
  assign room        = occ < Q_CNT_W'(Q_DEPTH);
  assign reads_above = !expect_q && !discard_q && (row_q != '0);
  assign haz         = reads_above && (q_hit_i ||
                       (s1_valid_q && s1_item_q.op == OP_DATA && s1_idx_q == column_q));
  assign in_stall_o  = !room || haz;
  assign accept      = in_valid_i && !in_stall_o;
  assign rd_addr_o   = column_q;

  assign last_row = (ROW_BYTES_W'(column_q) + ROW_BYTES_W'(1)) >= rb_i;
  assign last_img = last_row && ((IMAGE_ROWS_W'(row_q) + IMAGE_ROWS_W'(1)) >= rows_i);

  always_comb begin
    column_d   = column_q;
    row_d      = row_q;
    expect_d   = expect_q;
    discard_d  = discard_q;
    s1_valid_d = 1'b0;
    s1_item_d  = '{op: OP_FILTER, raw: raw_byte_i, last_row: last_row,
                   last_img: last_img, first_row: (row_q == '0)};
    if (accept) begin
      if (expect_q) begin
        expect_d = 1'b0;
        column_d = '0;
        if (!discard_q) begin
          s1_valid_d = 1'b1;
          if (raw_byte_i > 8'(FLT_PAETH)) begin
            discard_d    = 1'b1;
            s1_item_d.op = OP_ERROR;
          end
        end
      end else begin
        if (!discard_q) begin
          s1_valid_d   = 1'b1;
          s1_item_d.op = OP_DATA;
        end
        if (last_row) begin
          expect_d = 1'b1;
          column_d = '0;
          if (last_img) begin
            row_d     = '0;
            discard_d = 1'b0;
          end else begin
            row_d = row_q + ROW_IDX_W'(1);
          end
        end else begin
          column_d = column_q + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q   <= '0;
      row_q      <= '0;
      expect_q   <= 1'b1;
      discard_q  <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      column_q   <= column_d;
      row_q      <= row_d;
      expect_q   <= expect_d;
      discard_q  <= discard_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= s1_item_d;
      s1_idx_q  <= column_q;
    end
  end

  assign push_valid_o = s1_valid_q;
  assign push_item_o  = s1_item_q;
  assign push_idx_o   = s1_idx_q;
  assign stat_o       = '{accept: accept, reads_above: reads_above};

endmodule

[rtl/png_unf_queue.sv]
// Four-entry queue between front and back; also flags pending line store
// writes to a given column. Depends on png_unf_pkg.
module png_unf_queue
  import png_unf_pkg::*;
#(
  parameter int unsigned AW = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  item_t              push_item_i,
  input  logic [AW-1:0]      push_idx_i,
  input  logic [7:0]         push_above_i,
  input  logic               pop_i,
  output logic               head_valid_o,
  output item_t              head_item_o,
  output logic [AW-1:0]      head_idx_o,
  output logic [7:0]         head_above_o,
  output logic [Q_CNT_W-1:0] count_o,
  input  logic [AW-1:0]      probe_idx_i,
  output logic               hit_o
);

  item_t              item_q  [Q_DEPTH];
  logic [AW-1:0]      idx_q   [Q_DEPTH];
  logic [7:0]         above_q [Q_DEPTH];
  logic [Q_DEPTH-1:0] valid_q, valid_d;
  logic [Q_PTR_W-1:0] wr_q, rd_q;
  logic [Q_CNT_W-1:0] count_q;
  logic               pop;

  assign pop = pop_i && valid_q[rd_q];

  always_comb begin
    valid_d = valid_q;
    if (pop) begin
      valid_d[rd_q] = 1'b0;
    end
    if (push_i) begin
      valid_d[wr_q] = 1'b1;
    end
  end

  always_comb begin
    hit_o = 1'b0;
    for (int i = 0; i < Q_DEPTH; i++) begin
      if (valid_q[i] && item_q[i].op == OP_DATA && idx_q[i] == probe_idx_i) begin
        hit_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      valid_q <= valid_d;
      wr_q    <= wr_q + Q_PTR_W'(push_i);
      rd_q    <= rd_q + Q_PTR_W'(pop);
      count_q <= count_q + Q_CNT_W'(push_i) - Q_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      item_q[wr_q]  <= push_item_i;
      idx_q[wr_q]   <= push_idx_i;
      above_q[wr_q] <= push_above_i;
    end
  end

  assign head_valid_o = valid_q[rd_q];
  assign head_item_o  = item_q[rd_q];
  assign head_idx_o   = idx_q[rd_q];
  assign head_above_o = above_q[rd_q];
  assign count_o      = count_q;

endmodule

[rtl/png_unf_back.sv]
// Back end: applies the row filter, updates the line store and holds the
// result register. Depends on png_unf_pkg.
module png_unf_back
  import png_unf_pkg::*;
#(
  parameter int unsigned MAX_PIXEL_BYTES = 4,
  parameter int unsigned AW              = 16,
  parameter int unsigned SW              = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [SW-1:0] bpp_sel_i,
  input  logic          head_valid_i,
  input  item_t         head_item_i,
  input  logic [AW-1:0] head_idx_i,
  input  logic [7:0]    head_above_i,
  output logic          pop_o,
  output logic          we_o,
  output logic [AW-1:0] waddr_o,
  output logic [7:0]    wdata_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    pixel_byte_o,
  output logic          last_in_row_o,
  output logic          last_in_image_o,
  output logic          bad_filter_o
);

  localparam int unsigned LW = 8 * MAX_PIXEL_BYTES;

  logic [LW-1:0] left_q, left_d;
  logic [LW-1:0] al_q, al_d;
  logic [2:0]    filter_q;
  logic          out_valid_q;
  logic [7:0]    pix_q;
  logic          lrow_q, limg_q, bad_q;

  logic          out_free;
  logic [7:0]    a, b, c, pred, val;
  logic [8:0]    sum_ab;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = head_valid_i && (head_item_i.op == OP_FILTER || out_free);

  always_comb begin
    a = '0;
    c = '0;
    for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
      if (bpp_sel_i == SW'(k)) begin
        a = left_q[8*k +: 8];
        c = al_q[8*k +: 8];
      end
    end
    if (head_item_i.first_row) begin
      c = '0;
    end
    b      = head_item_i.first_row ? 8'd0 : head_above_i;
    sum_ab = {1'b0, a} + {1'b0, b};
    case (filter_q)
      FLT_SUB:   pred = a;
      FLT_UP:    pred = b;
      FLT_AVG:   pred = sum_ab[8:1];
      FLT_PAETH: pred = paeth(a, b, c);
      default:   pred = '0;
    endcase
    val    = head_item_i.raw + pred;
    left_d = (left_q << 8) | LW'(val);
    al_d   = (al_q << 8) | LW'(b);
  end

  assign we_o    = pop_o && head_item_i.op == OP_DATA;
  assign waddr_o = head_idx_i;
  assign wdata_o = val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      al_q        <= '0;
      filter_q    <= FLT_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        case (head_item_i.op)
          OP_FILTER: begin
            left_q   <= '0;
            al_q     <= '0;
            filter_q <= head_item_i.raw[2:0];
          end
          OP_DATA: begin
            left_q <= left_d;
            al_q   <= al_d;
          end
          default: begin
          end
        endcase
      end
      if (pop_o && head_item_i.op != OP_FILTER) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_item_i.op != OP_FILTER) begin
      if (head_item_i.op == OP_DATA) begin
        pix_q  <= val;
        lrow_q <= head_item_i.last_row;
        limg_q <= head_item_i.last_img;
        bad_q  <= 1'b0;
      end else begin
        pix_q  <= '0;
        lrow_q <= 1'b0;
        limg_q <= 1'b0;
        bad_q  <= 1'b1;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_byte_o    = pix_q;
  assign last_in_row_o   = lrow_q;
  assign last_in_image_o = limg_q;
  assign bad_filter_o    = bad_q;

endmodule

[rtl/png_scanline_unfilter_top.sv]
// PNG scanline unfilter top level: config registers, front end, queue, back end
// and the previous-row line store. Depends on png_unf_pkg and all png_unf_* modules.
//
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid_i / in_stall_o   | raw_byte_i
//  out     | output    | out_valid_o / out_stall_i | pixel_byte_o, last_in_row_o,
//          |           |                           | last_in_image_o, bad_filter_o
//  cfg     | input     | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// One byte per cycle unless in_stall_o is high, filter bytes included; a data byte passes
// the read stage and the queue before its result is registered. With row_bytes of 1, from the
// second row on a data byte waits until the previous row's write to that column retires.
// Reset clears control state and presets the config registers; the line store is not cleared.
// Input stalls once the queue and the read stage together hold four transactions.
module png_scanline_unfilter_top
  import png_unf_pkg::*;
#(
  parameter int unsigned MAX_ROW_BYTES   = 65536,
  parameter int unsigned MAX_PIXEL_BYTES = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ROW_BYTES_W-1:0] cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             raw_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             pixel_byte_o,
  output logic                   last_in_row_o,
  output logic                   last_in_image_o,
  output logic                   bad_filter_o
);

  localparam int unsigned AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int unsigned SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam logic [ROW_BYTES_W-1:0] MaxRb  = ROW_BYTES_W'(MAX_ROW_BYTES);
  localparam logic [3:0]             MaxPix = 4'(MAX_PIXEL_BYTES);

  logic [ROW_BYTES_W-1:0]  row_bytes_q;
  logic [PIX_BYTES_W-1:0]  pixel_bytes_q;
  logic [IMAGE_ROWS_W-1:0] image_rows_q;
  logic [ROW_BYTES_W-1:0]  rb;
  logic [IMAGE_ROWS_W-1:0] rows;
  logic [3:0]              pix4;
  logic [SW-1:0]           bpp_sel;

  logic [AW-1:0]      rd_addr;
  logic [7:0]         rd_data;
  logic               push_valid;
  item_t              push_item;
  logic [AW-1:0]      push_idx;
  fstat_t             fstat;
  logic [Q_CNT_W-1:0] q_count;
  logic               q_hit;
  logic               head_valid;
  item_t              head_item;
  logic [AW-1:0]      head_idx;
  logic [7:0]         head_above;
  logic               pop;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [7:0]         wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q   <= ROW_BYTES_W'(4);
      pixel_bytes_q <= PIX_BYTES_W'(4);
      image_rows_q  <= IMAGE_ROWS_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ROW_BYTES:   row_bytes_q   <= cfg_data_i;
        CFG_PIXEL_BYTES: pixel_bytes_q <= cfg_data_i[PIX_BYTES_W-1:0];
        CFG_IMAGE_ROWS:  image_rows_q  <= cfg_data_i[IMAGE_ROWS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rb   = (row_bytes_q == '0) ? ROW_BYTES_W'(1) :
           (row_bytes_q > MaxRb) ? MaxRb : row_bytes_q;
    rows = (image_rows_q == '0) ? IMAGE_ROWS_W'(1) :
           (image_rows_q > ROWS_LIMIT) ? ROWS_LIMIT : image_rows_q;
    pix4 = {1'b0, pixel_bytes_q};
    if (pix4 == '0) begin
      bpp_sel = '0;
    end else if (pix4 > MaxPix) begin
      bpp_sel = SW'(MaxPix - 4'd1);
    end else begin
      bpp_sel = SW'(pix4 - 4'd1);
    end
  end

  png_unf_front #(.AW(AW)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rb_i         (rb),
    .rows_i       (rows),
    .in_valid_i   (in_valid_i),
    .raw_byte_i   (raw_byte_i),
    .in_stall_o   (in_stall_o),
    .rd_addr_o    (rd_addr),
    .q_count_i    (q_count),
    .q_hit_i      (q_hit),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_idx_o   (push_idx),
    .stat_o       (fstat)
  );

  png_unf_ram #(.WIDTH(8), .DEPTH(MAX_ROW_BYTES), .AW(AW)) u_line (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  png_unf_queue #(.AW(AW)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_valid),
    .push_item_i  (push_item),
    .push_idx_i   (push_idx),
    .push_above_i (rd_data),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_item_o  (head_item),
    .head_idx_o   (head_idx),
    .head_above_o (head_above),
    .count_o      (q_count),
    .probe_idx_i  (rd_addr),
    .hit_o        (q_hit)
  );

  png_unf_back #(.MAX_PIXEL_BYTES(MAX_PIXEL_BYTES), .AW(AW), .SW(SW)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .bpp_sel_i       (bpp_sel),
    .head_valid_i    (head_valid),
    .head_item_i     (head_item),
    .head_idx_i      (head_idx),
    .head_above_i    (head_above),
    .pop_o           (pop),
    .we_o            (we),
    .waddr_o         (waddr),
    .wdata_o         (wdata),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_byte_o    (pixel_byte_o),
    .last_in_row_o   (last_in_row_o),
    .last_in_image_o (last_in_image_o),
    .bad_filter_o    (bad_filter_o)
  );

`ifndef NO_ASSERTIONS
  a_bad_filter_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_filter_o |-> pixel_byte_o == 8'd0 && !last_in_row_o && !last_in_image_o)
    else $error("error result carries nonzero fields");

  a_no_stale_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstat.accept && fstat.reads_above && we |-> waddr != rd_addr)
    else $error("line store read collides with pending write");

  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (Q_CNT_W + 1)'(q_count) + (Q_CNT_W + 1)'(push_valid) <= (Q_CNT_W + 1)'(Q_DEPTH))
    else $error("queue overflow");

  a_pop_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid && q_count != '0)
    else $error("pop from empty queue");
`endif

endmodule

[verif/png_unf_sb_pkg.sv]
// Scoreboard for the PNG scanline unfilter: rebuilds every data byte from the raw
// stream and checks the results in order. Depends on png_unf_pkg.
package png_unf_sb_pkg;
  import png_unf_pkg::*;

  localparam int unsigned LINE_BYTES = 65536;
  localparam int unsigned PIXEL_MAX  = 4;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last_row;
    logic       last_img;
    logic       bad;
  } pixel_result_t;

  class unfilter_scoreboard;
    logic [ROW_BYTES_W-1:0]  row_bytes_reg;
    logic [PIX_BYTES_W-1:0]  pix_bytes_reg;
    logic [IMAGE_ROWS_W-1:0] rows_reg;
    logic [7:0]              line_store[LINE_BYTES];
    logic [31:0]             left_hist;
    logic [31:0]             upleft_hist;
    int unsigned             column;
    int unsigned             row_idx;
    logic [2:0]              row_filter;
    bit                      want_filter;
    bit                      skipping;
    pixel_result_t           pixel_queue[$];
    int unsigned             mismatches;

    function new();
      row_bytes_reg = 17'd4;
      pix_bytes_reg = 3'd4;
      rows_reg      = 15'd1;
      foreach (line_store[i]) line_store[i] = 8'h00;
      left_hist     = '0;
      upleft_hist   = '0;
      column        = 0;
      row_idx       = 0;
      row_filter    = FLT_NONE;
      want_filter   = 1'b1;
      skipping      = 1'b0;
      mismatches    = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v == 0) begin
        return 1;
      end
      return (v > hi) ? hi : v;
    endfunction

    function int unsigned paeth_choice(int a, int b, int c);
      int p;
      int da;
      int db;
      int dc;
      p  = a + b - c;
      da = (p > a) ? p - a : a - p;
      db = (p > b) ? p - b : b - p;
      dc = (p > c) ? p - c : c - p;
      if (da <= db && da <= dc) begin
        return a;
      end else if (db <= dc) begin
        return b;
      end
      return c;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_BYTES_W-1:0] data);
      case (idx)
        CFG_ROW_BYTES:   row_bytes_reg = data;
        CFG_PIXEL_BYTES: pix_bytes_reg = data[PIX_BYTES_W-1:0];
        CFG_IMAGE_ROWS:  rows_reg = data[IMAGE_ROWS_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned row_len();
      return clamp(row_bytes_reg, LINE_BYTES);
    endfunction

    function bit at_filter();
      return want_filter;
    endfunction

    function bit at_image_start();
      return want_filter && row_idx == 0;
    endfunction

    function int unsigned pending();
      return pixel_queue.size();
    endfunction

    // Returns one unless the byte falls in a discarded image.
    function bit take_raw_byte(logic [7:0] raw);
      int unsigned   rb;
      int unsigned   bpp;
      int unsigned   rows;
      int unsigned   x;
      int unsigned   a;
      int unsigned   b;
      int unsigned   c;
      int unsigned   pred;
      int unsigned   shift;
      logic [7:0]    v;
      bit            row_end;
      bit            img_end;
      bit            kept;
      pixel_result_t r;
      rb   = clamp(row_bytes_reg, LINE_BYTES);
      bpp  = clamp(pix_bytes_reg, PIXEL_MAX);
      rows = clamp(rows_reg, ROWS_LIMIT);
      x    = column;
      kept = !skipping;
      if (want_filter) begin
        want_filter = 1'b0;
        column      = 0;
        left_hist   = '0;
        upleft_hist = '0;
        if (skipping) begin
          return 1'b0;
        end
        if (raw > FLT_PAETH) begin
          skipping = 1'b1;
          r = '{pixel: 8'h00, last_row: 1'b0, last_img: 1'b0, bad: 1'b1};
          pixel_queue.push_back(r);
        end else begin
          row_filter = raw[2:0];
        end
        return 1'b1;
      end
      row_end = (x + 1 >= rb);
      img_end = row_end && (row_idx + 1 >= rows);
      if (!skipping) begin
        shift = 8 * (bpp - 1);
        a = (left_hist >> shift) & 32'hFF;
        c = (upleft_hist >> shift) & 32'hFF;
        b = (row_idx == 0) ? 0 : line_store[x];
        if (row_idx == 0) begin
          c = 0;
        end
        case (row_filter)
          FLT_SUB:   pred = a;
          FLT_UP:    pred = b;
          FLT_AVG:   pred = (a + b) >> 1;
          FLT_PAETH: pred = paeth_choice(a, b, c);
          default:   pred = 0;
        endcase
        v = 8'(raw + pred);
        line_store[x] = v;
        left_hist     = {left_hist[23:0], v};
        upleft_hist   = {upleft_hist[23:0], 8'(b)};
        r = '{pixel: v, last_row: row_end, last_img: img_end, bad: 1'b0};
        pixel_queue.push_back(r);
      end
      if (row_end) begin
        want_filter = 1'b1;
        column      = 0;
        if (img_end) begin
          row_idx  = 0;
          skipping = 1'b0;
        end else begin
          row_idx++;
        end
      end else begin
        column = x + 1;
      end
      return kept;
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_pixel(pixel_result_t got);
      pixel_result_t want;
      if (pixel_queue.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        return;
      end
      want = pixel_queue.pop_front();
      compare_field("pixel_byte", want.pixel, got.pixel);
      compare_field("last_in_row", 8'(want.last_row), 8'(got.last_row));
      compare_field("last_in_image", 8'(want.last_img), 8'(got.last_img));
      compare_field("bad_filter", 8'(want.bad), 8'(got.bad));
    endfunction
  endclass

endpackage

[verif/tb.sv]
// Testbench top for png_scanline_unfilter_top: drives image streams and register
// writes with random gaps and stalls. Depends on png_unf_pkg and png_unf_sb_pkg.
module tb
  import png_unf_pkg::*, png_unf_sb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS  = 850;
  localparam int unsigned MAX_GAP       = 6;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned STUCK_LIMIT   = 2000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [ROW_BYTES_W-1:0] cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [7:0]             raw_byte_i = 8'h00;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [7:0]             pixel_byte_o;
  logic                   last_in_row_o;
  logic                   last_in_image_o;
  logic                   bad_filter_o;

  unfilter_scoreboard sb = new;
  bit                 gaps_on = 1'b1;
  int unsigned        random_items = 0;
  int unsigned        stuck_cycles = 0;

  png_scanline_unfilter_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .raw_byte_i     (raw_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_byte_o   (pixel_byte_o),
    .last_in_row_o  (last_in_row_o),
    .last_in_image_o(last_in_image_o),
    .bad_filter_o   (bad_filter_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    if (sb.take_raw_byte(b)) begin
      random_items++;
    end
  endtask

  task automatic send_list(input logic [7:0] list[$]);
    foreach (list[i]) send_byte(list[i]);
  endtask

  task automatic send_next();
    logic [7:0] b;
    if (!sb.at_filter()) begin
      b = 8'($urandom);
    end else if ($urandom_range(0, 29) == 0) begin
      b = 8'($urandom_range(5, 255));
    end else begin
      b = 8'($urandom_range(0, 4));
    end
    send_byte(b);
  endtask

  task automatic send_images(input int unsigned count);
    repeat (count) begin
      do send_next(); while (!sb.at_image_start());
    end
  endtask

  // Hold input until every outstanding transaction has come out.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [ROW_BYTES_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_pixel({pixel_byte_o, last_in_row_o, last_in_image_o, bad_filter_o});
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : receiver
    int unsigned hold;
    @(posedge clk_i);
    forever begin
      hold = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : stimulus
    int unsigned rb;
    bit          tall;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_list('{FLT_NONE, 8'h00, 8'hFF, 8'h80, 8'h7F});
    settle();
    write_reg(CFG_ROW_BYTES, 17'd3);
    write_reg(CFG_PIXEL_BYTES, 17'h1FFF8);
    write_reg(CFG_IMAGE_ROWS, 17'd3);
    write_reg(CFG_UNUSED, 17'h1FFFF);
    send_list('{FLT_PAETH, 8'hFF, 8'h01, 8'h80, FLT_AVG, 8'hFF, 8'hFF, 8'h00,
                FLT_SUB, 8'h01, 8'hFE, 8'h7F});
    settle();
    write_reg(CFG_ROW_BYTES, 17'd0);
    write_reg(CFG_IMAGE_ROWS, 17'd2);
    send_list('{8'h05, 8'h12, 8'hFF, 8'h34, FLT_UP, 8'hAA, FLT_UP, 8'h55});

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      settle();
      gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: rb = $urandom_range(0, 8);
        6, 7, 8:          rb = $urandom_range(9, 48);
        default:          rb = $urandom_range(49, 100);
      endcase
      tall = ($urandom_range(0, 3) == 0);
      write_reg(CFG_ROW_BYTES, 17'(rb));
      write_reg(CFG_PIXEL_BYTES, 17'($urandom));
      if (tall) begin
        write_reg(CFG_IMAGE_ROWS, {2'($urandom), 15'($urandom_range(16, 32767))});
        repeat ($urandom_range(1, 4 * rb + 4)) send_next();
        settle();
        write_reg(CFG_IMAGE_ROWS, {2'($urandom), 15'($urandom_range(0, 2))});
        if ($urandom_range(0, 1) != 0) begin
          write_reg(CFG_PIXEL_BYTES, 17'($urandom));
        end
        if ($urandom_range(0, 1) != 0) begin
          write_reg(CFG_ROW_BYTES, 17'($urandom_range(0, sb.row_len())));
        end
        while (!sb.at_image_start()) send_next();
      end else begin
        write_reg(CFG_IMAGE_ROWS, {2'($urandom), 15'($urandom_range(0, 4))});
        send_images($urandom_range(1, 3));
      end
    end

    settle();
    gaps_on = 1'b0;
    write_reg(CFG_ROW_BYTES, 17'h1FFFF);
    write_reg(CFG_IMAGE_ROWS, 17'd2);
    write_reg(CFG_PIXEL_BYTES, 17'($urandom));
    repeat (41) send_next();
    settle();
    write_reg(CFG_ROW_BYTES, 17'd16);
    while (!sb.at_image_start()) send_next();

    settle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
